FILE: rtl/orf_pkg.sv
// Shared types and constants for the order fill reconciler.
package orf_pkg;

   localparam int ORDER_SLOTS = 1024;
   localparam int SLOT_W      = $clog2(ORDER_SLOTS);
   localparam logic [31:0] QTY_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_MODIFY = 2'd1,
      OP_REMOVE = 2'd2,
      OP_TRADE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_MODIFY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_APPLY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic        side;
      logic [31:0] price;
      logic [31:0] qty;
   } rest_entry_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic [63:0] stamp;
      logic [31:0] qty;
   } credit_entry_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] id;
      logic [31:0] price;
      logic [31:0] qty;
      logic        side;
      logic [63:0] stamp;
   } result_type;

endpackage

FILE: rtl/orf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module orf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

FILE: rtl/order_fill_reconciler.sv
// Order fill reconciler top level: shadow order book, credit ledger, sequencer.
//
//   channel | direction | ports                         | contents
//   req     | in        | req_tvalid/tready/tdata/tuser | one feed event (tuser: opcode)
//   rsp     | out       | rsp_tvalid/tready/tdata/tuser | one status or correction
//                       | rsp_tlast                     | final result of an event
//
// Each pass scans the resting and credit RAMs side by side, one slot per cycle
// with one key compare per table, through the scan, tail and apply states.
// An event is accepted while idle, then takes one pass for add, modify and
// remove and two for a trade, then emits results while rsp_tready is high.
// After reset a clearing pass over all slots runs with req_tready low.
// req_tready is high only while idle; a stalled rsp holds the block.
module order_fill_reconciler (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // event_time[63:0], buy_id[127:64], sell_id[191:128], price[223:192],
   // quantity[255:224], side[256], amount_traded[288:257], zero pad[295:289]
   input  logic [295:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // corr_id[63:0], price_out[95:64], quantity_out[127:96], side_out[128],
   // time_out[192:129], stale_fill_count[224:193],
   // unmatched_remove_count[256:225], table_full[257], zero pad[263:258]
   output logic [263:0] rsp_tdata,
   // correction_kind[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);
   import orf_pkg::*;

   state_type        state_ff, state_in;
   logic [SLOT_W:0]  cnt_ff, cnt_in;
   logic             chk_ff, chk_in;
   logic [SLOT_W-1:0] chk_idx_ff, chk_idx_in;

   opcode_type       op_ff, op_in;
   logic [63:0]      time_ff, time_in, id_ff, id_in, sell_ff, sell_in;
   logic [31:0]      price_ff, price_in, qty_ff, qty_in, amt_ff, amt_in;
   logic             side_ff, side_in;
   logic             pass_ff, pass_in;

   logic             rhit_ff, rhit_in, rfree_ff, rfree_in;
   logic [SLOT_W-1:0] ridx_ff, ridx_in, rfidx_ff, rfidx_in;
   rest_entry_type   rent_ff, rent_in;
   logic             chit_ff, chit_in, cfree_ff, cfree_in;
   logic [SLOT_W-1:0] cidx_ff, cidx_in, cfidx_ff, cfidx_in;
   credit_entry_type cent_ff, cent_in;

   logic [31:0]      stale_ff, stale_in, unm_ff, unm_in;
   logic             full_ff, full_in;
   logic [1:0]       nres_ff, nres_in;
   logic             sel_ff, sel_in;
   result_type       res_ff [2];
   result_type       res_in [2];

   logic             rest_we, credit_we;
   logic [SLOT_W-1:0] rest_waddr, credit_waddr, rd_addr;
   rest_entry_type   rest_wdata, rest_rdata;
   credit_entry_type credit_wdata, credit_rdata;

   logic [63:0]      cur_key;
   logic [31:0]      sf, cov, cq_new;
   logic [32:0]      csum;
   result_type       cur_res;
   logic             out_last;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == QTY_MAX) ? v : v + 32'd1;
   endfunction

   orf_ram #(.WIDTH($bits(rest_entry_type)), .DEPTH(ORDER_SLOTS)) u_rest_ram (
      .clock      (clock),
      .wr_en      (rest_we),
      .wr_addr    (rest_waddr),
      .wr_data    (rest_wdata),
      .rd_addr    (rd_addr),
      .rd_data_ff (rest_rdata)
   );

   orf_ram #(.WIDTH($bits(credit_entry_type)), .DEPTH(ORDER_SLOTS)) u_credit_ram (
      .clock      (clock),
      .wr_en      (credit_we),
      .wr_addr    (credit_waddr),
      .wr_data    (credit_wdata),
      .rd_addr    (rd_addr),
      .rd_data_ff (credit_rdata)
   );

   assign cur_key = pass_ff ? sell_ff : id_ff;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      chk_in     = chk_ff;
      chk_idx_in = chk_idx_ff;
      op_in      = op_ff;
      time_in    = time_ff;
      id_in      = id_ff;
      sell_in    = sell_ff;
      price_in   = price_ff;
      qty_in     = qty_ff;
      amt_in     = amt_ff;
      side_in    = side_ff;
      pass_in    = pass_ff;
      rhit_in    = rhit_ff;
      ridx_in    = ridx_ff;
      rent_in    = rent_ff;
      rfree_in   = rfree_ff;
      rfidx_in   = rfidx_ff;
      chit_in    = chit_ff;
      cidx_in    = cidx_ff;
      cent_in    = cent_ff;
      cfree_in   = cfree_ff;
      cfidx_in   = cfidx_ff;
      stale_in   = stale_ff;
      unm_in     = unm_ff;
      full_in    = full_ff;
      nres_in    = nres_ff;
      sel_in     = sel_ff;
      res_in[0]  = res_ff[0];
      res_in[1]  = res_ff[1];
      rest_we      = 1'b0;
      rest_waddr   = cnt_ff[SLOT_W-1:0];
      rest_wdata   = '0;
      credit_we    = 1'b0;
      credit_waddr = cnt_ff[SLOT_W-1:0];
      credit_wdata = '0;
      rd_addr      = cnt_ff[SLOT_W-1:0];
      sf      = qty_ff;
      cov     = '0;
      cq_new  = cent_ff.qty;
      csum    = {1'b0, cent_ff.qty} + {1'b0, amt_ff};
      cur_res = '0;

      // compare the slot read in the previous cycle
      if (chk_ff) begin
         if (rest_rdata.valid && rest_rdata.key == cur_key && !rhit_ff) begin
            rhit_in = 1'b1;
            ridx_in = chk_idx_ff;
            rent_in = rest_rdata;
         end
         if (!rest_rdata.valid && !rfree_ff) begin
            rfree_in = 1'b1;
            rfidx_in = chk_idx_ff;
         end
         if (credit_rdata.valid && credit_rdata.key == cur_key && !chit_ff) begin
            chit_in = 1'b1;
            cidx_in = chk_idx_ff;
            cent_in = credit_rdata;
         end
         if (!credit_rdata.valid && !cfree_ff) begin
            cfree_in = 1'b1;
            cfidx_in = chk_idx_ff;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            rest_we   = 1'b1;
            credit_we = 1'b1;
            if (cnt_ff == (SLOT_W+1)'(ORDER_SLOTS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = opcode_type'(req_tuser);
               time_in  = req_tdata[63:0];
               id_in    = req_tdata[127:64];
               sell_in  = req_tdata[191:128];
               price_in = req_tdata[223:192];
               qty_in   = req_tdata[255:224];
               side_in  = req_tdata[256];
               amt_in   = req_tdata[288:257];
               pass_in  = 1'b0;
               full_in  = 1'b0;
               nres_in  = '0;
               sel_in   = 1'b0;
               cnt_in   = '0;
               chk_in   = 1'b0;
               rhit_in  = 1'b0;
               rfree_in = 1'b0;
               chit_in  = 1'b0;
               cfree_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            chk_in     = 1'b1;
            chk_idx_in = cnt_ff[SLOT_W-1:0];
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == (SLOT_W+1)'(ORDER_SLOTS - 1)) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            chk_in   = 1'b0;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            case (op_ff)
               OP_ADD, OP_MODIFY: begin
                  rest_wdata = '{valid: 1'b1, key: id_ff, side: side_ff,
                                 price: price_ff, qty: qty_ff};
                  if (rhit_ff) begin
                     rest_we    = 1'b1;
                     rest_waddr = ridx_ff;
                  end else if (rfree_ff) begin
                     rest_we    = 1'b1;
                     rest_waddr = rfidx_ff;
                  end else begin
                     full_in = 1'b1;
                  end
                  if (op_ff == OP_MODIFY) begin
                     credit_wdata = '{valid: 1'b1, key: id_ff, stamp: time_ff, qty: amt_ff};
                     if (!chit_ff) begin
                        if (amt_ff != '0) begin
                           if (cfree_ff) begin
                              credit_we    = 1'b1;
                              credit_waddr = cfidx_ff;
                           end else begin
                              full_in = 1'b1;
                           end
                        end
                     end else if (cent_ff.stamp == time_ff) begin
                        credit_we    = 1'b1;
                        credit_waddr = cidx_ff;
                        credit_wdata = cent_ff;
                        credit_wdata.qty = csum[32] ? QTY_MAX : csum[31:0];
                     end else begin
                        if (cent_ff.qty != '0) begin
                           stale_in = sat_inc(stale_ff);
                        end
                        credit_we    = 1'b1;
                        credit_waddr = cidx_ff;
                        if (amt_ff == '0) begin
                           credit_wdata = cent_ff;
                           credit_wdata.valid = 1'b0;
                        end
                     end
                  end
               end
               OP_REMOVE: begin
                  if (rhit_ff) begin
                     rest_we    = 1'b1;
                     rest_waddr = ridx_ff;
                     rest_wdata = rent_ff;
                     rest_wdata.valid = 1'b0;
                  end
                  if (chit_ff) begin
                     if (cent_ff.qty != '0 && cent_ff.stamp != time_ff) begin
                        unm_in = sat_inc(unm_ff);
                     end
                     credit_we    = 1'b1;
                     credit_waddr = cidx_ff;
                     credit_wdata = cent_ff;
                     credit_wdata.valid = 1'b0;
                  end
               end
               OP_TRADE: begin
                  if (rhit_ff) begin
                     if (chit_ff) begin
                        credit_we    = 1'b1;
                        credit_waddr = cidx_ff;
                        credit_wdata = cent_ff;
                        if (cent_ff.stamp == time_ff) begin
                           cov    = (qty_ff < cent_ff.qty) ? qty_ff : cent_ff.qty;
                           sf     = qty_ff - cov;
                           cq_new = cent_ff.qty - cov;
                           credit_wdata.qty   = cq_new;
                           credit_wdata.valid = (cq_new != '0);
                        end else begin
                           if (cent_ff.qty != '0) begin
                              stale_in = sat_inc(stale_ff);
                           end
                           credit_wdata.valid = 1'b0;
                        end
                     end
                     if (sf != '0) begin
                        rest_we    = 1'b1;
                        rest_waddr = ridx_ff;
                        rest_wdata = rent_ff;
                        cur_res.id    = cur_key;
                        cur_res.price = rent_ff.price;
                        cur_res.side  = rent_ff.side;
                        cur_res.stamp = time_ff;
                        if (sf >= rent_ff.qty) begin
                           cur_res.kind = KIND_REMOVE;
                           cur_res.qty  = rent_ff.qty;
                           rest_wdata.valid = 1'b0;
                        end else begin
                           cur_res.kind = KIND_MODIFY;
                           cur_res.qty  = rent_ff.qty - sf;
                           rest_wdata.qty = rent_ff.qty - sf;
                        end
                        res_in[nres_ff[0]] = cur_res;
                        nres_in = nres_ff + 2'd1;
                     end
                  end
               end
               default: begin
               end
            endcase
            // second pass of a trade looks up the sell order
            if (op_ff == OP_TRADE && !pass_ff) begin
               pass_in  = 1'b1;
               cnt_in   = '0;
               rhit_in  = 1'b0;
               rfree_in = 1'b0;
               chit_in  = 1'b0;
               cfree_in = 1'b0;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (out_last) begin
                  state_in = ST_IDLE;
               end else begin
                  sel_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign out_last   = (nres_ff != 2'd2) || sel_ff;

   result_type out_res;
   assign out_res   = (nres_ff == '0) ? '0 : res_ff[sel_ff];
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_last;
   assign rsp_tdata = {6'd0, full_ff, unm_ff, stale_ff, out_res.stamp, out_res.side,
                       out_res.qty, out_res.price, out_res.id};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         chk_ff   <= 1'b0;
         stale_ff <= '0;
         unm_ff   <= '0;
         rhit_ff  <= 1'b0;
         rfree_ff <= 1'b0;
         chit_ff  <= 1'b0;
         cfree_ff <= 1'b0;
         pass_ff  <= 1'b0;
         nres_ff  <= '0;
         sel_ff   <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         chk_ff   <= chk_in;
         stale_ff <= stale_in;
         unm_ff   <= unm_in;
         rhit_ff  <= rhit_in;
         rfree_ff <= rfree_in;
         chit_ff  <= chit_in;
         cfree_ff <= cfree_in;
         pass_ff  <= pass_in;
         nres_ff  <= nres_in;
         sel_ff   <= sel_in;
         full_ff  <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      op_ff      <= op_in;
      time_ff    <= time_in;
      id_ff      <= id_in;
      sell_ff    <= sell_in;
      price_ff   <= price_in;
      qty_ff     <= qty_in;
      amt_ff     <= amt_in;
      side_ff    <= side_in;
      ridx_ff    <= ridx_in;
      rent_ff    <= rent_in;
      rfidx_ff   <= rfidx_in;
      cidx_ff    <= cidx_in;
      cent_ff    <= cent_in;
      cfidx_ff   <= cfidx_in;
      res_ff[0]  <= res_in[0];
      res_ff[1]  <= res_in[1];
   end

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_EMIT) |-> !(rest_we || credit_we))
      else $error("table written outside apply or clear");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after final response");

   a_status_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && op_ff != OP_TRADE) |-> (rsp_tuser == KIND_NONE && rsp_tlast))
      else $error("non-trade event produced a correction");
`endif

endmodule

FILE: tb/order_fill_reconciler_check.sv
// Checker: tracks the order book and credit ledger, predicts and compares results.
`timescale 1ns / 100ps

module order_fill_reconciler_check (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [295:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [263:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   output int           mismatches,
   output int           outstanding
);
   import orf_pkg::*;

   typedef struct {
      kind_type    kind;
      logic [63:0] id;
      logic [31:0] price;
      logic [31:0] qty;
      logic        side;
      logic [63:0] stamp;
      logic        last;
      logic [31:0] stale;
      logic [31:0] unmatched;
      logic        full;
   } fill_result_type;

   logic        book_valid [ORDER_SLOTS];
   logic [63:0] book_key   [ORDER_SLOTS];
   logic        book_side  [ORDER_SLOTS];
   logic [31:0] book_price [ORDER_SLOTS];
   logic [31:0] book_qty   [ORDER_SLOTS];
   logic        cred_valid [ORDER_SLOTS];
   logic [63:0] cred_key   [ORDER_SLOTS];
   logic [63:0] cred_stamp [ORDER_SLOTS];
   logic [31:0] cred_qty   [ORDER_SLOTS];
   logic [31:0] stale_cnt;
   logic [31:0] unmatched_cnt;

   fill_result_type pending_results[$];

   assign outstanding = pending_results.size();

   function automatic int find_order(logic [63:0] key);
      for (int i = 0; i < ORDER_SLOTS; i++)
         if (book_valid[i] && book_key[i] == key) return i;
      return -1;
   endfunction

   function automatic int find_credit(logic [63:0] key);
      for (int i = 0; i < ORDER_SLOTS; i++)
         if (cred_valid[i] && cred_key[i] == key) return i;
      return -1;
   endfunction

   function automatic int free_order();
      for (int i = 0; i < ORDER_SLOTS; i++)
         if (!book_valid[i]) return i;
      return -1;
   endfunction

   function automatic int free_credit();
      for (int i = 0; i < ORDER_SLOTS; i++)
         if (!cred_valid[i]) return i;
      return -1;
   endfunction

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == QTY_MAX) ? v : v + 32'd1;
   endfunction

   // Insert or update a resting order; return 0 when the book is full.
   function automatic bit place_order(logic [63:0] key, logic sd, logic [31:0] px,
                                      logic [31:0] q);
      int s;
      s = find_order(key);
      if (s < 0) s = free_order();
      if (s < 0) return 0;
      book_valid[s] = 1'b1;
      book_key[s]   = key;
      book_side[s]  = sd;
      book_price[s] = px;
      book_qty[s]   = q;
      return 1;
   endfunction

   task automatic reconcile(logic [1:0] op_bits, logic [295:0] d);
      opcode_type   op;
      logic [63:0]  t, id, sell, key;
      logic [31:0]  px, q, amt, shortfall, cov, sum;
      logic         sd;
      bit           full;
      int           c, r;
      fill_result_type batch[$];
      fill_result_type e;
      op   = opcode_type'(op_bits);
      t    = d[63:0];
      id   = d[127:64];
      sell = d[191:128];
      px   = d[223:192];
      q    = d[255:224];
      sd   = d[256];
      amt  = d[288:257];
      full = 0;
      case (op)
         OP_ADD: begin
            if (!place_order(id, sd, px, q)) full = 1;
         end
         OP_MODIFY: begin
            if (!place_order(id, sd, px, q)) full = 1;
            c = find_credit(id);
            if (c < 0) begin
               if (amt != 0) begin
                  c = free_credit();
                  if (c < 0) full = 1;
                  else begin
                     cred_valid[c] = 1'b1;
                     cred_key[c]   = id;
                     cred_stamp[c] = t;
                     cred_qty[c]   = amt;
                  end
               end
            end else if (cred_stamp[c] == t) begin
               sum = cred_qty[c] + amt;
               cred_qty[c] = (sum < amt) ? QTY_MAX : sum;
            end else begin
               if (cred_qty[c] != 0) stale_cnt = sat_inc(stale_cnt);
               if (amt != 0) begin
                  cred_stamp[c] = t;
                  cred_qty[c]   = amt;
               end else cred_valid[c] = 1'b0;
            end
         end
         OP_REMOVE: begin
            r = find_order(id);
            if (r >= 0) book_valid[r] = 1'b0;
            c = find_credit(id);
            if (c >= 0) begin
               if (cred_qty[c] != 0 && cred_stamp[c] != t)
                  unmatched_cnt = sat_inc(unmatched_cnt);
               cred_valid[c] = 1'b0;
            end
         end
         default: begin
            // buy side first, then sell; the same id may pass twice
            for (int p = 0; p < 2; p++) begin
               key = (p == 0) ? id : sell;
               shortfall = q;
               r = find_order(key);
               if (r >= 0) begin
                  c = find_credit(key);
                  if (c >= 0) begin
                     if (cred_stamp[c] == t) begin
                        cov = (shortfall < cred_qty[c]) ? shortfall : cred_qty[c];
                        shortfall   -= cov;
                        cred_qty[c] -= cov;
                        if (cred_qty[c] == 0) cred_valid[c] = 1'b0;
                     end else begin
                        if (cred_qty[c] != 0) stale_cnt = sat_inc(stale_cnt);
                        cred_valid[c] = 1'b0;
                     end
                  end
                  if (shortfall != 0) begin
                     e.id    = key;
                     e.price = book_price[r];
                     e.side  = book_side[r];
                     e.stamp = t;
                     if (shortfall >= book_qty[r]) begin
                        e.kind = KIND_REMOVE;
                        e.qty  = book_qty[r];
                        book_valid[r] = 1'b0;
                     end else begin
                        e.kind = KIND_MODIFY;
                        e.qty  = book_qty[r] - shortfall;
                        book_qty[r] = e.qty;
                     end
                     batch = {batch, e};
                  end
               end
            end
         end
      endcase
      if (batch.size() == 0) begin
         e.kind = KIND_NONE; e.id = '0; e.price = '0; e.qty = '0; e.side = 1'b0;
         e.stamp = '0;
         batch = {batch, e};
      end
      foreach (batch[k]) begin
         batch[k].last      = (k == batch.size() - 1);
         batch[k].stale     = stale_cnt;
         batch[k].unmatched = unmatched_cnt;
         batch[k].full      = full;
         pending_results = {pending_results, batch[k]};
      end
   endtask

   task automatic compare_result();
      fill_result_type e, a;
      a.kind      = kind_type'(rsp_tuser);
      a.id        = rsp_tdata[63:0];
      a.price     = rsp_tdata[95:64];
      a.qty       = rsp_tdata[127:96];
      a.side      = rsp_tdata[128];
      a.stamp     = rsp_tdata[192:129];
      a.stale     = rsp_tdata[224:193];
      a.unmatched = rsp_tdata[256:225];
      a.full      = rsp_tdata[257];
      a.last      = rsp_tlast;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: kind=%0d id=%h qty=%h", a.kind, a.id, a.qty);
         return;
      end
      e = pending_results.pop_front();
      if (a.kind !== e.kind || a.id !== e.id || a.price !== e.price || a.qty !== e.qty
          || a.side !== e.side || a.stamp !== e.stamp || a.last !== e.last
          || a.stale !== e.stale || a.unmatched !== e.unmatched || a.full !== e.full
          || rsp_tdata[263:258] !== 6'd0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch exp: kind=%0d id=%h px=%h qty=%h side=%b t=%h last=%b",
                     e.kind, e.id, e.price, e.qty, e.side, e.stamp, e.last);
            $display("              stale=%0d unm=%0d full=%b",
                     e.stale, e.unmatched, e.full);
            $display("         act: kind=%0d id=%h px=%h qty=%h side=%b t=%h last=%b",
                     a.kind, a.id, a.price, a.qty, a.side, a.stamp, a.last);
            $display("              stale=%0d unm=%0d full=%b",
                     a.stale, a.unmatched, a.full);
         end
      end
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ORDER_SLOTS; i++) begin
            book_valid[i] = 1'b0;
            cred_valid[i] = 1'b0;
         end
         stale_cnt     = '0;
         unmatched_cnt = '0;
         pending_results.delete();
      end else begin
         if (req_tvalid && req_tready) reconcile(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) compare_result();
      end
   end

endmodule

FILE: tb/order_fill_reconciler_test.sv
// Testbench top: clock, reset, request stimulus, response backpressure and verdict.
`timescale 1ns / 100ps

module order_fill_reconciler_test;
   import orf_pkg::*;

   localparam int IDLE_LIMIT = 40000;
   localparam int HOLD_CYCLES = 6000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // event_time, buy_id, sell_id, price, quantity, side, amount_traded, pad
   logic [295:0] req_tdata;
   // opcode
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // corr_id, price_out, quantity_out, side_out, time_out, stale_fill_count,
   // unmatched_remove_count, table_full, pad
   logic [263:0] rsp_tdata;
   // correction_kind
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   int mismatches, outstanding;
   int send_idle_pct, recv_stall_pct;
   bit hold_go;
   bit hold_used = 1'b0;
   int hold_left = 0;
   int quiet_cycles;
   logic [63:0] id_pool[12];
   logic [63:0] stamp_pool[4];

   order_fill_reconciler dut (.*);

   order_fill_reconciler_check checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .mismatches, .outstanding
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Response backpressure, with one long hold-off that stalls the block.
   always @(posedge clock) begin
      if (hold_go && !hold_used) begin
         hold_used = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("order_fill_reconciler_test: done, errors");
         $finish;
      end
   end

   task automatic send_request(opcode_type op, logic [63:0] t, logic [63:0] id,
                               logic [63:0] sell, logic [31:0] px, logic [31:0] q,
                               logic sd, logic [31:0] amt);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, amt, sd, q, px, sell, id, t};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [63:0] pick_id();
      if ($urandom_range(99) < 5) return {$urandom, $urandom};
      return id_pool[$urandom_range(11)];
   endfunction

   function automatic logic [63:0] pick_stamp();
      if ($urandom_range(99) < 8) return {$urandom, $urandom};
      return stamp_pool[$urandom_range(3)];
   endfunction

   function automatic logic [31:0] pick_qty();
      int r;
      r = $urandom_range(99);
      if (r < 8) return $urandom;
      if (r < 12) return QTY_MAX;
      if (r < 16) return 32'd0;
      return $urandom_range(1, 30);
   endfunction

   task automatic random_request();
      int r;
      opcode_type op;
      r = $urandom_range(99);
      op = (r < 25) ? OP_ADD : (r < 55) ? OP_MODIFY : (r < 70) ? OP_REMOVE : OP_TRADE;
      send_request(op, pick_stamp(), pick_id(), pick_id(), $urandom, pick_qty(),
                   1'($urandom_range(1)), pick_qty());
   endtask

   task automatic set_phase(int n);
      case ((n / 150) % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
         default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
   endtask

   localparam logic [63:0] ID_A = 64'h1, ID_B = 64'h2, ONES = '1;

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_ADD;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_go = 0;
      id_pool[0] = '0;
      id_pool[1] = ONES;
      for (int i = 2; i < 12; i++) id_pool[i] = 64'(i - 1);
      stamp_pool = '{64'd5, 64'd6, 64'd7, ONES};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: book building, covered and uncovered fills, stale credit
      send_request(OP_ADD, 64'd1, ID_A, 0, QTY_MAX, 32'd10, 1'b0, 0);
      send_request(OP_ADD, 64'd1, ID_B, 0, 32'd77, 32'd5, 1'b1, 0);
      send_request(OP_MODIFY, 64'd100, ID_A, 0, QTY_MAX, 32'd10, 1'b0, 32'd3);
      send_request(OP_TRADE, 64'd100, ID_A, ID_B, 0, 32'd5, 1'b0, 0);
      send_request(OP_TRADE, 64'd100, ID_A, ID_A, 0, 32'd2, 1'b0, 0);
      send_request(OP_TRADE, 64'd100, 64'h55, 64'h66, 0, 32'd4, 1'b0, 0);
      send_request(OP_MODIFY, 64'd200, ID_A, 0, 32'd9, 32'd8, 1'b0, 32'd4);
      send_request(OP_MODIFY, 64'd300, ID_A, 0, 32'd9, 32'd8, 1'b0, 32'd6);
      send_request(OP_TRADE, 64'd400, ID_A, 64'h66, 0, 32'd0, 1'b0, 0);
      send_request(OP_MODIFY, 64'd500, ID_A, 0, 32'd9, 32'd8, 1'b0, 32'd2);
      send_request(OP_REMOVE, 64'd501, ID_A, 0, 0, 0, 1'b0, 0);
      send_request(OP_REMOVE, 64'd501, ID_A, 0, 0, 0, 1'b0, 0);
      // credit saturation at the extremes of every field
      send_request(OP_MODIFY, ONES, ONES, ONES, QTY_MAX, QTY_MAX, 1'b1, QTY_MAX);
      send_request(OP_MODIFY, ONES, ONES, ONES, QTY_MAX, QTY_MAX, 1'b1, QTY_MAX);
      send_request(OP_TRADE, ONES, ONES, ONES, QTY_MAX, QTY_MAX, 1'b1, QTY_MAX);
      send_request(OP_ADD, 64'd0, 64'd0, 0, 32'd0, 32'd0, 1'b0, 0);
      send_request(OP_TRADE, 64'd0, 64'd0, 64'd0, 0, 32'd1, 1'b0, 0);
      send_request(OP_ADD, 64'd7, ID_B, 0, 32'd3, 32'd4, 1'b1, 0);
      send_request(OP_MODIFY, 64'd7, ID_B, 0, 32'd3, 32'd4, 1'b1, 32'd0);
      send_request(OP_TRADE, 64'd7, ONES, ID_B, 0, QTY_MAX, 1'b0, 0);
      send_request(OP_REMOVE, 64'd9, 64'h77, 0, 0, 0, 1'b0, 0);

      for (int n = 0; n < 750; n++) begin
         set_phase(n);
         if (n == 320) hold_go = 1;
         random_request();
      end

      // fill both tables with fresh keys, then push past capacity
      for (int n = 0; n < ORDER_SLOTS + 6; n++) begin
         set_phase(n);
         send_request(OP_MODIFY, 64'd6, 64'hF000_0000_0000_0000 + n, 0, $urandom,
                      $urandom_range(1, 20), 1'($urandom_range(1)), 32'd1);
      end
      send_request(OP_ADD, 64'd6, 64'hE000_0000_0000_0001, 0, 32'd1, 32'd1, 1'b0, 0);
      for (int n = 0; n < 40; n++) begin
         set_phase(n * 150);
         if ($urandom_range(1))
            send_request(OP_TRADE, 64'd6, 64'hF000_0000_0000_0000 + $urandom_range(1100),
                         64'hF000_0000_0000_0000 + $urandom_range(1100), 0, pick_qty(),
                         1'b0, 0);
         else random_request();
      end
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("order_fill_reconciler_test: done, clean");
      else
         $display("order_fill_reconciler_test: done, errors");
      $finish;
   end

endmodule

FILE: files.f
rtl/orf_pkg.sv
rtl/orf_ram.sv
rtl/order_fill_reconciler.sv
tb/order_fill_reconciler_check.sv
tb/order_fill_reconciler_test.sv
